>>> hdl/spp_pkg.sv
// Shared types and constants for the spectral peak picker.
// No dependencies; the other files that use it refer to it by scoped names.
package spp_pkg;

  // Field and register widths
  localparam int unsigned BIN_W   = 24;
  localparam int unsigned SR_W    = 18;
  localparam int unsigned BF_W    = 10;
  localparam int unsigned THR_W   = 23;
  localparam int unsigned FREQ_W  = 10;
  localparam int unsigned SQ_W    = 47;
  localparam int unsigned MAG_W   = 48;
  localparam int unsigned THRSQ_W = 46;

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_SAMPLE_RATE = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_BAND_FLOOR  = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_AMP_THRESH  = 4'h8;

  localparam logic [SR_W-1:0]  RST_SAMPLE_RATE = 18'd44100;
  localparam logic [BF_W-1:0]  RST_BAND_FLOOR  = 10'd181;
  localparam logic [THR_W-1:0] RST_AMP_THRESH  = 23'd10000;

  // Frequency arithmetic. After the shift by log2(FFT_SIZE) the scaled bin
  // position is below 2^17 for any legal sample rate, so division by 100 is a
  // multiply by a rounded-up reciprocal followed by a shift of 24.
  localparam int unsigned Q_W         = 17;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned QP_W        = Q_W + RECIP_W;
  localparam int unsigned FRAW_W      = QP_W - RECIP_SHIFT;
  localparam logic [Q_W-1:0]     ROUND_OFFS = 17'd50;
  localparam logic [RECIP_W-1:0] RECIP_100  = 18'd167773;
  localparam logic [FREQ_W-1:0]  FREQ_MAX   = 10'd1023;

  // Classification flags handed from the front end to the back end
  typedef struct packed {
    logic ws;   // bin 0 of a new window: history is cleared
    logic chk;  // bin 2 or later: the previous bin may be a peak
  } flags_t;

  localparam int unsigned FLAGS_W = $bits(flags_t);

endpackage

>>> hdl/spectral_peak_picker_unit.sv
// Top level of the spectral peak picker: configuration registers, front end,
// middle queue, back-end pipeline and result queue. Depends on spp_pkg, spp_front, spp_fifo, spp_back.
//
//  Channel   Ports                                            Handshake
//  input     in_bin_real, in_bin_imag, in_window_start        push / full
//  result    out_peak_frequency                               pop / empty
//  config    psel, penable, pwrite, paddr, pwdata, prdata     pready (always high)
//
// One bin is taken every cycle while full is low; the back end is a four-stage pipeline.
// A peak reaches the result side once the bin that follows it is pushed, passing the
// middle queue and the stage 1, stage 2 and stage 3 registers in that order.
// Reset is synchronous and clears both queues, the bin count and the history.
// The back end halts only while the result queue is full; the middle queue then
// absorbs bins until full rises. FFT_SIZE must be a power of two.
module spectral_peak_picker_unit #(
  parameter int unsigned FFT_SIZE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [spp_pkg::BIN_W-1:0]  in_bin_real,
  input  logic signed [spp_pkg::BIN_W-1:0]  in_bin_imag,
  input  logic                              in_window_start,
  input  logic                              push,
  output logic                              full,
  output logic [spp_pkg::FREQ_W-1:0]        out_peak_frequency,
  output logic                              empty,
  input  logic                              pop,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spp_pkg::ADDR_W-1:0]        paddr,
  input  logic [spp_pkg::DATA_W-1:0]        pwdata,
  output logic [spp_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int unsigned KIW = $clog2(FFT_SIZE / 2);
  localparam int unsigned QW  = KIW + spp_pkg::FLAGS_W + 2 * spp_pkg::BIN_W;

  logic [spp_pkg::SR_W-1:0]  fs_cfg_r;
  logic [spp_pkg::BF_W-1:0]  band_floor_r;
  logic [spp_pkg::THR_W-1:0] amp_thresh_r;

  logic                  mq_wr;
  logic                  mq_rd;
  logic                  mq_full;
  logic                  mq_empty;
  logic [QW-1:0]         mq_rdata;
  logic [KIW-1:0]        fe_km1;
  spp_pkg::flags_t       fe_flags;
  logic                  oq_wr;
  logic                  oq_full;
  logic [spp_pkg::FREQ_W-1:0] oq_wdata;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_cfg_r     <= spp_pkg::RST_SAMPLE_RATE;
      band_floor_r <= spp_pkg::RST_BAND_FLOOR;
      amp_thresh_r <= spp_pkg::RST_AMP_THRESH;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        spp_pkg::ADDR_SAMPLE_RATE: fs_cfg_r     <= pwdata[spp_pkg::SR_W-1:0];
        spp_pkg::ADDR_BAND_FLOOR:  band_floor_r <= pwdata[spp_pkg::BF_W-1:0];
        spp_pkg::ADDR_AMP_THRESH:  amp_thresh_r <= pwdata[spp_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      spp_pkg::ADDR_SAMPLE_RATE: prdata = spp_pkg::DATA_W'(fs_cfg_r);
      spp_pkg::ADDR_BAND_FLOOR:  prdata = spp_pkg::DATA_W'(band_floor_r);
      spp_pkg::ADDR_AMP_THRESH:  prdata = spp_pkg::DATA_W'(amp_thresh_r);
      default:                   prdata = '0;
    endcase
  end

  spp_front #(
    .FFT_SIZE (FFT_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .q_full       (mq_full),
    .window_start (in_window_start),
    .q_wr         (mq_wr),
    .km1          (fe_km1),
    .flags        (fe_flags)
  );

  assign full = mq_full;

  spp_fifo #(
    .W     (QW),
    .DEPTH (4)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mq_wr),
    .wr_data ({fe_km1, fe_flags, in_bin_real, in_bin_imag}),
    .rd_en   (mq_rd),
    .rd_data (mq_rdata),
    .full    (mq_full),
    .empty   (mq_empty)
  );

  spp_back #(
    .FFT_SIZE (FFT_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (mq_empty),
    .q_data      (mq_rdata),
    .q_rd        (mq_rd),
    .o_full      (oq_full),
    .o_wr        (oq_wr),
    .o_data      (oq_wdata),
    .fs_cfg      (fs_cfg_r),
    .band_floor  (band_floor_r),
    .amp_thresh  (amp_thresh_r)
  );

  spp_fifo #(
    .W     (spp_pkg::FREQ_W),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_wr),
    .wr_data (oq_wdata),
    .rd_en   (pop),
    .rd_data (out_peak_frequency),
    .full    (oq_full),
    .empty   (empty)
  );

endmodule

>>> hdl/spp_fifo.sv
// Small register-based queue used between front and back end and on the result side.
// Depends on nothing; DEPTH must be a power of two.
module spp_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/spp_front.sv
// Front end: accepts bins, tracks the position in the window and classifies each word.
// Depends on spp_pkg; feeds the middle queue.
module spp_front #(
  parameter int unsigned FFT_SIZE = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           q_full,
  input  logic                           window_start,
  output logic                           q_wr,
  output logic [$clog2(FFT_SIZE/2)-1:0]  km1,
  output spp_pkg::flags_t                flags
);

  localparam int unsigned HALF_BINS = FFT_SIZE / 2;
  localparam int unsigned CNT_W     = $clog2(HALF_BINS + 1);
  localparam int unsigned KIW       = $clog2(HALF_BINS);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [KIW-1:0]   k;
  logic             accept;
  logic             keep;

  assign accept = push && !q_full;

  // Bins past the first half are swallowed here: they change nothing downstream.
  always_comb begin
    keep    = 1'b0;
    k       = '0;
    cnt_nxt = cnt_r;
    if (window_start) begin
      keep    = 1'b1;
      cnt_nxt = CNT_W'(1);
    end else if (cnt_r < CNT_W'(HALF_BINS)) begin
      keep    = 1'b1;
      k       = cnt_r[KIW-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign q_wr      = accept && keep;
  assign km1       = k - KIW'(1);
  assign flags.ws  = window_start;
  assign flags.chk = (k >= KIW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/spp_back.sv
// Back end: four-stage pipeline for squares, peak test, frequency and repeat handling.
// Depends on spp_pkg; reads the middle queue and writes the result queue.
module spp_back #(
  parameter int unsigned FFT_SIZE = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  logic [$clog2(FFT_SIZE/2)+spp_pkg::FLAGS_W+2*spp_pkg::BIN_W-1:0] q_data,
  output logic                                   q_rd,
  input  logic                                   o_full,
  output logic                                   o_wr,
  output logic [spp_pkg::FREQ_W-1:0]             o_data,
  input  logic [spp_pkg::SR_W-1:0]               fs_cfg,
  input  logic [spp_pkg::BF_W-1:0]               band_floor,
  input  logic [spp_pkg::THR_W-1:0]              amp_thresh
);

  localparam int unsigned FFT_LOG2 = $clog2(FFT_SIZE);
  localparam int unsigned KIW      = $clog2(FFT_SIZE / 2);
  localparam int unsigned PW       = KIW + spp_pkg::SR_W;

  logic                                en;
  logic [KIW-1:0]                      d_km1;
  spp_pkg::flags_t                     d_flg;
  logic signed [spp_pkg::BIN_W-1:0]    d_re;
  logic signed [spp_pkg::BIN_W-1:0]    d_im;
  logic signed [2*spp_pkg::BIN_W-1:0]  sq_re_full;
  logic signed [2*spp_pkg::BIN_W-1:0]  sq_im_full;

  // Stage 1
  logic                      s1_v_r;
  spp_pkg::flags_t           s1_flg_r;
  logic [spp_pkg::SQ_W-1:0]  s1_sq_re_r;
  logic [spp_pkg::SQ_W-1:0]  s1_sq_im_r;
  logic [PW-1:0]             s1_fprod_r;
  // Stage 2
  logic                      s2_v_r;
  spp_pkg::flags_t           s2_flg_r;
  logic [spp_pkg::MAG_W-1:0] s2_mag_r;
  logic [spp_pkg::Q_W-1:0]   s2_q_r;
  // Stage 3
  logic                      s3_v_r;
  logic                      s3_ws_r;
  logic                      s3_pk_r;
  logic [spp_pkg::QP_W-1:0]  s3_qp_r;
  // History and repeat state
  logic [spp_pkg::MAG_W-1:0]   mag_prev_r;
  logic [spp_pkg::MAG_W-1:0]   mag_prev2_r;
  logic [spp_pkg::THRSQ_W-1:0] thr_sq_r;
  logic [spp_pkg::FREQ_W-1:0]  last_r;
  logic                        last_v_r;

  logic                        pk_nxt;
  logic [spp_pkg::FRAW_W-1:0]  f_raw;
  logic                        emit;
  logic [spp_pkg::FREQ_W-1:0]  f_sat;
  logic [spp_pkg::FREQ_W-1:0]  f_out;

  // The whole pipeline moves together; it only halts while the result queue is full.
  assign en   = !o_full;
  assign q_rd = en && !q_empty;

  assign {d_km1, d_flg, d_re, d_im} = q_data;
  assign sq_re_full = d_re * d_re;
  assign sq_im_full = d_im * d_im;

  always_ff @(posedge clk) begin
    thr_sq_r <= spp_pkg::THRSQ_W'(amp_thresh) * spp_pkg::THRSQ_W'(amp_thresh);
  end

  // Stage 1: squares of both parts and the bin-times-rate product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flg_r   <= d_flg;
      s1_sq_re_r <= sq_re_full[spp_pkg::SQ_W-1:0];
      s1_sq_im_r <= sq_im_full[spp_pkg::SQ_W-1:0];
      s1_fprod_r <= PW'(d_km1) * PW'(fs_cfg);
    end
  end

  // Stage 2: magnitude sum; the rounding term 50*N becomes 50 after the shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_flg_r <= s1_flg_r;
      s2_mag_r <= spp_pkg::MAG_W'(s1_sq_re_r) + spp_pkg::MAG_W'(s1_sq_im_r);
      s2_q_r   <= spp_pkg::Q_W'(s1_fprod_r >> FFT_LOG2) + spp_pkg::ROUND_OFFS;
    end
  end

  // Stage 3: local maximum test against the two-bin history and the multiply by the reciprocal
  assign pk_nxt = s2_flg_r.chk && (mag_prev2_r < mag_prev_r) &&
                  (mag_prev_r > s2_mag_r) &&
                  (mag_prev_r > spp_pkg::MAG_W'(thr_sq_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r      <= 1'b0;
      mag_prev_r  <= '0;
      mag_prev2_r <= '0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
      if (s2_v_r) begin
        mag_prev2_r <= s2_flg_r.ws ? '0 : mag_prev_r;
        mag_prev_r  <= s2_mag_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ws_r <= s2_flg_r.ws;
      s3_pk_r <= pk_nxt;
      s3_qp_r <= spp_pkg::QP_W'(s2_q_r) * spp_pkg::QP_W'(spp_pkg::RECIP_100);
    end
  end

  // Stage 4: band floor, saturation and the nudge for a repeated frequency
  assign f_raw = s3_qp_r[spp_pkg::QP_W-1:spp_pkg::RECIP_SHIFT];
  assign emit  = s3_pk_r && (f_raw > spp_pkg::FRAW_W'(band_floor));
  assign f_sat = (f_raw > spp_pkg::FRAW_W'(spp_pkg::FREQ_MAX)) ? spp_pkg::FREQ_MAX
                                                               : f_raw[spp_pkg::FREQ_W-1:0];

  always_comb begin
    f_out = f_sat;
    if (last_v_r && (f_sat == last_r) && (f_sat != spp_pkg::FREQ_MAX)) begin
      f_out = f_sat + spp_pkg::FREQ_W'(1);
    end
  end

  assign o_wr   = en && s3_v_r && emit;
  assign o_data = f_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      last_v_r <= 1'b0;
    end else if (en && s3_v_r) begin
      if (s3_ws_r) begin
        last_v_r <= 1'b0;
      end else if (emit) begin
        last_r   <= f_out;
        last_v_r <= 1'b1;
      end
    end
  end

endmodule

>>> hdl/spp_checker.sv
// Port-level checks for the spectral peak picker, bound to the top level.
// Depends on spp_pkg and spectral_peak_picker_unit.
module spp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              full,
  input logic [spp_pkg::FREQ_W-1:0]        out_peak_frequency,
  input logic                              empty,
  input logic                              pop,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [spp_pkg::ADDR_W-1:0]        paddr,
  input logic [spp_pkg::DATA_W-1:0]        pwdata,
  input logic [spp_pkg::DATA_W-1:0]        prdata,
  input logic                              pready
);

  // A word waiting on the result side holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_peak_frequency)))
    else $error("result word changed or vanished while waiting");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_rst_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  // A sample rate written is read back unchanged.
  a_sr_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && paddr == spp_pkg::ADDR_SAMPLE_RATE) |=>
    (paddr != spp_pkg::ADDR_SAMPLE_RATE ||
     prdata[spp_pkg::SR_W-1:0] == $past(pwdata[spp_pkg::SR_W-1:0])))
    else $error("sample rate read-back mismatch");

endmodule

bind spectral_peak_picker_unit spp_checker u_spp_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spectral_peak_picker_unit: bins go in through the push/full
// queue, peak frequencies are predicted locally and checked word by word on pop/empty.
// Depends on spp_pkg and the RTL of the block; reads no files.
module tb;

  localparam int unsigned FFT_LEN      = 1024;
  localparam int unsigned HALF_BINS    = FFT_LEN / 2;
  localparam int unsigned ITEMS        = 900;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned LONG_BINS    = HALF_BINS + 18;
  localparam int          IDLE_PCT     = 28;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [spp_pkg::ADDR_W-1:0] ADDR_SPARE = 4'hC;

  typedef struct packed {
    logic [spp_pkg::BIN_W-1:0] re;
    logic [spp_pkg::BIN_W-1:0] im;
    logic                      ws;
  } bin_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic signed [spp_pkg::BIN_W-1:0] in_bin_real = '0;
  logic signed [spp_pkg::BIN_W-1:0] in_bin_imag = '0;
  logic in_window_start = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [spp_pkg::FREQ_W-1:0] out_peak_frequency;
  logic empty;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [spp_pkg::ADDR_W-1:0] paddr = '0;
  logic [spp_pkg::DATA_W-1:0] pwdata = '0;
  logic [spp_pkg::DATA_W-1:0] prdata;
  logic pready;

  spectral_peak_picker_unit #(.FFT_SIZE(FFT_LEN)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_bin_real(in_bin_real), .in_bin_imag(in_bin_imag), .in_window_start(in_window_start),
    .push(push), .full(full),
    .out_peak_frequency(out_peak_frequency), .empty(empty), .pop(pop),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Local copy of the configuration and of the peak tracking state
  logic [spp_pkg::SR_W-1:0]   rate_q  = spp_pkg::RST_SAMPLE_RATE;
  logic [spp_pkg::BF_W-1:0]   floor_q = spp_pkg::RST_BAND_FLOOR;
  logic [spp_pkg::THR_W-1:0]  thr_q   = spp_pkg::RST_AMP_THRESH;
  int unsigned                bin_pos = 0;
  logic [63:0]                pow_prev = '0;
  logic [63:0]                pow_prev2 = '0;
  logic [spp_pkg::FREQ_W-1:0] last_freq = '0;
  logic                       last_valid = 1'b0;

  logic [spp_pkg::FREQ_W-1:0] peaks_due[$];
  bin_word_t                  bins_waiting[$];
  bin_word_t                  bin_offered;
  bit                         offered = 1'b0;
  bit                         tx_quiet = 1'b0;
  bit                         rx_quiet = 1'b0;
  int unsigned                rx_hold_left = 0;
  int unsigned                item_total = 0;
  int unsigned                fail_count = 0;
  logic [spp_pkg::FREQ_W-1:0] want_freq;

  task automatic track_bin(input bin_word_t b);
    logic [63:0] pow, thr_sq, num, freq;
    longint sre, sim;
    if (b.ws) begin
      bin_pos = 0;
      pow_prev = '0;
      pow_prev2 = '0;
      last_valid = 1'b0;
    end
    if (bin_pos >= HALF_BINS) return;
    sre = longint'($signed(b.re));
    sim = longint'($signed(b.im));
    pow = 64'(sre * sre + sim * sim);
    // The bin before this one is the candidate; bins 0 and 1 only fill the history.
    if (bin_pos >= 2) begin
      thr_sq = 64'(thr_q) * 64'(thr_q);
      num = 64'(bin_pos - 1) * 64'(rate_q) + 64'(50 * FFT_LEN);
      freq = num / 64'(100 * FFT_LEN);
      if (freq > 64'(floor_q) && pow_prev2 < pow_prev && pow_prev > pow &&
          pow_prev > thr_sq) begin
        if (freq > 64'(spp_pkg::FREQ_MAX)) freq = 64'(spp_pkg::FREQ_MAX);
        if (last_valid && freq == 64'(last_freq) && freq < 64'(spp_pkg::FREQ_MAX)) begin
          freq = freq + 1;
        end
        last_freq = freq[spp_pkg::FREQ_W-1:0];
        last_valid = 1'b1;
        peaks_due.insert(peaks_due.size(), freq[spp_pkg::FREQ_W-1:0]);
      end
    end
    pow_prev2 = pow_prev;
    pow_prev = pow;
    bin_pos++;
  endtask

  // Input side: a word is taken at the edge where push is high and full is low.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      track_bin(bin_offered);
      offered = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (!offered && bins_waiting.size() != 0 &&
          (tx_quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        bin_offered = bins_waiting.pop_front();
        offered = 1'b1;
      end
      push <= offered;
      if (offered) begin
        in_bin_real <= bin_offered.re;
        in_bin_imag <= bin_offered.im;
        in_window_start <= bin_offered.ws;
      end else begin
        in_bin_real <= spp_pkg::BIN_W'($urandom);
        in_bin_imag <= spp_pkg::BIN_W'($urandom);
        in_window_start <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Result side
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (peaks_due.size() == 0) begin
        $error("peak_frequency: expected no word, actual %0d", out_peak_frequency);
        fail_count++;
      end else begin
        want_freq = peaks_due.pop_front();
        if (out_peak_frequency !== want_freq) begin
          $error("peak_frequency: expected %0d, actual %0d", want_freq, out_peak_frequency);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic apb_write(input logic [spp_pkg::ADDR_W-1:0] addr,
                           input logic [spp_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      spp_pkg::ADDR_SAMPLE_RATE: rate_q = data[spp_pkg::SR_W-1:0];
      spp_pkg::ADDR_BAND_FLOOR:  floor_q = data[spp_pkg::BF_W-1:0];
      spp_pkg::ADDR_AMP_THRESH:  thr_q = data[spp_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [spp_pkg::ADDR_W-1:0] addr,
                          output logic [spp_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [spp_pkg::DATA_W-1:0] rd;
    apb_read(spp_pkg::ADDR_SAMPLE_RATE, rd);
    if (rd !== spp_pkg::DATA_W'(rate_q)) begin
      $error("sample rate: expected %0d, actual %0d", rate_q, rd);
      fail_count++;
    end
    apb_read(spp_pkg::ADDR_BAND_FLOOR, rd);
    if (rd !== spp_pkg::DATA_W'(floor_q)) begin
      $error("band_floor: expected %0d, actual %0d", floor_q, rd);
      fail_count++;
    end
    apb_read(spp_pkg::ADDR_AMP_THRESH, rd);
    if (rd !== spp_pkg::DATA_W'(thr_q)) begin
      $error("amplitude_threshold: expected %0d, actual %0d", thr_q, rd);
      fail_count++;
    end
  endtask

  // Upper bits of each write carry junk that the block must drop.
  task automatic set_regs(input logic [spp_pkg::SR_W-1:0] sr,
                          input logic [spp_pkg::BF_W-1:0] bf,
                          input logic [spp_pkg::THR_W-1:0] thr);
    logic [spp_pkg::DATA_W-1:0] w;
    w = $urandom;
    w[spp_pkg::SR_W-1:0] = sr;
    apb_write(spp_pkg::ADDR_SAMPLE_RATE, w);
    w = $urandom;
    w[spp_pkg::BF_W-1:0] = bf;
    apb_write(spp_pkg::ADDR_BAND_FLOOR, w);
    w = $urandom;
    w[spp_pkg::THR_W-1:0] = thr;
    apb_write(spp_pkg::ADDR_AMP_THRESH, w);
    check_regs();
  endtask

  task automatic add_bin(input int re, input int im, input bit ws);
    bin_word_t b;
    b.re = spp_pkg::BIN_W'(re);
    b.im = spp_pkg::BIN_W'(im);
    b.ws = ws;
    bins_waiting.insert(bins_waiting.size(), b);
    item_total++;
  endtask

  function automatic int rand_part(input bit big);
    if (!big) return int'($urandom_range(0, 2000)) - 1000;
    case ($urandom_range(0, 5))
      0: return -8388608;
      1: return 8388607;
      default: return int'($urandom);
    endcase
  endfunction

  // This waits until every bin is sent and every peak is back, then the pipeline is left to drain
  // of words that give no peak before the registers may change.
  task automatic settle();
    while (bins_waiting.size() != 0 || offered || peaks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [spp_pkg::SR_W-1:0]  sr;
    logic [spp_pkg::BF_W-1:0]  bf;
    logic [spp_pkg::THR_W-1:0] thr;
    int unsigned phase, phase_items, len, big_pct, k;
    bit fresh, ws, big;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_regs();

    // Directed: a start without window start, a repeated frequency and the threshold edge.
    set_regs(18'd8000, 10'd0, 23'd5);
    add_bin(0, 0, 1'b0);
    add_bin(-8388608, 8388607, 1'b0);
    add_bin(-1, -1, 1'b0);
    add_bin(0, 0, 1'b1);
    add_bin(1, 0, 1'b0);
    add_bin(0, -1, 1'b0);
    add_bin(2, 2, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(3, -3, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(-8388608, -8388608, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(8388607, -8388608, 1'b0);
    add_bin(-1, 0, 1'b0);
    add_bin(0, 0, 1'b1);
    add_bin(0, 0, 1'b0);
    add_bin(5, 0, 1'b0);
    add_bin(0, 5, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(3, 4, 1'b0);
    add_bin(0, 0, 1'b0);
    add_bin(4, 4, 1'b0);
    add_bin(0, 1, 1'b0);
    settle();

    // A full window at the widest sample rate: high bins saturate, and the bins past
    // the half window are dropped. The receiver holds off so that both queues fill.
    set_regs({spp_pkg::SR_W{1'b1}}, 10'd0, 23'd0);
    apb_write(ADDR_SPARE, $urandom);
    check_regs();
    @(posedge clk);
    tx_quiet = 1'b1;
    rx_hold_left = HOLD_CYCLES;
    for (k = 0; k < LONG_BINS; k++) begin
      big = (k % 2 == 1) ^ ($urandom_range(0, 9) == 0);
      add_bin(rand_part(big), rand_part(big && $urandom_range(0, 1) == 1), k == 0);
    end
    settle();
    tx_quiet = 1'b0;

    phase = 0;
    while (item_total < ITEMS) begin
      case (phase % 6)
        0: begin
          sr = 18'd8000;
          bf = 10'd0;
          thr = spp_pkg::THR_W'($urandom_range(0, 300));
        end
        1: begin
          sr = 18'd192000;
          bf = {spp_pkg::BF_W{1'b1}};
          thr = 23'd0;
        end
        2: begin
          sr = {spp_pkg::SR_W{1'b1}};
          bf = spp_pkg::BF_W'($urandom_range(0, 20));
          thr = {spp_pkg::THR_W{1'b1}};
        end
        3: begin
          sr = spp_pkg::SR_W'($urandom_range(0, 262143));
          bf = spp_pkg::BF_W'($urandom_range(0, 15));
          thr = spp_pkg::THR_W'($urandom_range(0, 4095));
        end
        4: begin
          sr = 18'd44100;
          bf = spp_pkg::BF_W'($urandom_range(0, 3));
          thr = spp_pkg::THR_W'($urandom_range(0, 8388607));
        end
        default: begin
          sr = spp_pkg::SR_W'($urandom_range(8000, 192000));
          bf = 10'd0;
          thr = 23'd0;
        end
      endcase
      set_regs(sr, bf, thr);
      @(posedge clk);
      rx_quiet = (phase == 0);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = $urandom_range(3, 48);
        big_pct = ($urandom_range(0, 9) < 7) ? 40 : $urandom_range(0, 100);
        fresh = ($urandom_range(0, 9) != 0);
        for (k = 0; k < len; k++) begin
          ws = (k == 0 && fresh) || ($urandom_range(0, 99) == 0);
          big = $urandom_range(0, 99) < big_pct;
          add_bin(rand_part(big), rand_part(big && $urandom_range(0, 1) == 1), ws);
        end
        phase_items += len;
      end
      settle();
      rx_quiet = 1'b0;
      phase++;
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/spp_pkg.sv
hdl/spp_fifo.sv
hdl/spp_front.sv
hdl/spp_back.sv
hdl/spectral_peak_picker_unit.sv
hdl/spp_checker.sv
tb/sv/tb.sv
